/* rtl/core/dshot_frame_decoder_assert.svh */
// Assertion macros for the DShot frame decoder checker.
// Expects clk and arst_n in the scope of use.
`ifndef DSHOT_FRAME_DECODER_ASSERT_SVH
`define DSHOT_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define DFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dfd assertion failed");

// next-cycle implication
`define DFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dfd assertion failed");

`endif

/* rtl/core/dfd_pkg.sv */
// Shared types and constants for the DShot frame decoder.
// No dependencies.
`default_nettype none
package dfd_pkg;
	localparam int FRAME_BITS = 16;
	localparam int POS_W      = 4;
	localparam int DIFF_W     = 16;
	localparam int THR_W      = 17;
	localparam int THROT_W    = 11;
	localparam int CNT_W      = 7;

	localparam logic [DIFF_W-1:0] DIFF_LIMIT    = 16'd64000;
	localparam logic [DIFF_W-1:0] DIFF_INIT     = 16'hFFFF;
	localparam logic [CNT_W-1:0]  RESTART_LIMIT = 7'd100;
	localparam logic [CNT_W-1:0]  CNT_MAX       = 7'd127;
	localparam logic [POS_W-1:0]  LAST_POS      = POS_W'(FRAME_BITS - 1);

	typedef enum logic [0:0] {
		CFG_AUTO_DETECT     = 1'b0,
		CFG_FIXED_THRESHOLD = 1'b1
	} cfg_idx_t;

	typedef logic [FRAME_BITS-1:0][DIFF_W-1:0] diff_arr_t;

	typedef struct packed {
		logic [DIFF_W-1:0] min_diff;
		logic              bad;
		logic              auto_det;
		logic [DIFF_W-1:0] fixed_thr;
		logic              stopped;
	} frame_end_t;
endpackage
`default_nettype wire

/* rtl/core/dfd_bit_acc.sv */
// Per-bit accumulation: difference store, frame minimum, fault/restart tracking,
// config registers and the frame-end register. Uses dfd_pkg.
`default_nettype none
module dfd_bit_acc
	import dfd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [DIFF_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DIFF_W-1:0] period_capture,
	input  wire logic [DIFF_W-1:0] edge_capture,
	input  wire logic              res_free,
	output logic                   fe_valid_s1,
	output frame_end_t             fe_s1,
	output diff_arr_t              store_q
);
	logic              auto_q;
	logic [DIFF_W-1:0] fixed_q;
	logic [POS_W-1:0]  pos_q;
	logic [DIFF_W-1:0] min_q;
	logic              bad_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              stopped_q;

	logic [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] min_nx;
	logic              bad_nx;
	logic [CNT_W-1:0]  cnt_inc;
	logic              stop_nx;
	logic              take;
	logic              last;

	// hold input while a finished frame waits, the store must stay intact
	assign in_ready = !fe_valid_s1 || res_free;
	assign take     = in_valid && in_ready && !stopped_q;
	assign last     = (pos_q == LAST_POS);

	always_comb begin
		diff    = period_capture - edge_capture;
		min_nx  = (diff < min_q) ? diff : min_q;
		bad_nx  = bad_q || (diff > DIFF_LIMIT);
		cnt_inc = (cnt_q != CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
		stop_nx = stopped_q || (bad_nx && (cnt_inc >= RESTART_LIMIT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q  <= 1'b1;
			fixed_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_AUTO_DETECT:     auto_q  <= cfg_data[0];
				CFG_FIXED_THRESHOLD: fixed_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			min_q     <= DIFF_INIT;
			bad_q     <= 1'b0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				pos_q <= '0;
				min_q <= DIFF_INIT;
				bad_q <= 1'b0;
				if (bad_nx) begin
					cnt_q <= cnt_inc;
				end
				stopped_q <= stop_nx;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				min_q <= min_nx;
				bad_q <= bad_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_valid_s1 <= 1'b0;
		end else if (take && last) begin
			fe_valid_s1 <= 1'b1;
		end else if (res_free) begin
			fe_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			fe_s1.min_diff  <= min_nx;
			fe_s1.bad       <= bad_nx;
			fe_s1.auto_det  <= auto_q;
			fe_s1.fixed_thr <= fixed_q;
			fe_s1.stopped   <= stop_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			store_q[pos_q] <= diff;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/dfd_frame_judge.sv */
// Frame judgment: threshold, bit slicing, CRC check, held throttle and the
// result register. Uses dfd_pkg.
`default_nettype none
module dfd_frame_judge
	import dfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fe_valid_s1,
	input  wire frame_end_t         fe_s1,
	input  wire diff_arr_t          store_q,
	output logic                    res_free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [THROT_W-1:0]      throttle_value,
	output logic                    value_updated,
	output logic                    frame_fault,
	output logic                    halted
);
	logic [THR_W-1:0]      thr;
	logic [FRAME_BITS-1:0] word;
	logic [11:0]           value;
	logic [3:0]            crc_calc;
	logic                  upd;
	logic                  load;
	logic [THROT_W-1:0]    held_q;

	assign res_free = !out_valid || out_ready;
	assign load     = fe_valid_s1 && res_free;

	always_comb begin
		if (fe_s1.auto_det) begin
			thr = {1'b0, fe_s1.min_diff} + {2'b00, fe_s1.min_diff[DIFF_W-1:1]};
		end else begin
			thr = {1'b0, fe_s1.fixed_thr};
		end
		for (int i = 0; i < FRAME_BITS; i++) begin
			word[FRAME_BITS-1-i] = ({1'b0, store_q[i]} > thr);
		end
		value    = word[15:4];
		crc_calc = value[3:0] ^ value[7:4] ^ value[11:8];
		upd      = !fe_s1.bad && (crc_calc == word[3:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load && upd) begin
				held_q <= value[11:1];
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			throttle_value <= upd ? value[11:1] : held_q;
			value_updated  <= upd;
			frame_fault    <= fe_s1.bad;
			halted         <= fe_s1.stopped;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/dshot_frame_decoder.sv */
// DShot frame decoder top level.
// Instantiates dfd_bit_acc and dfd_frame_judge; uses dfd_pkg.
//
// Input channel: one word per DShot bit (period_capture, edge_capture).
// Sixteen words make a frame; the sixteenth produces one result word on the
// output channel (throttle_value, value_updated, frame_fault, halted),
// all other words produce none.
// Config channel: cfg_index 0 = auto_detect, 1 = fixed_threshold; always ready,
// write only while no frame is in progress.
// Throughput: one input word per cycle while in_ready is high.
// The result of a frame is registered in the frame-end register, then in the
// result register, after the last bit of the frame is accepted.
// Stall: the result register holds while out_ready is low; one finished frame
// may wait behind it, after which in_ready drops until the result is taken.
// Reset: bit position, restart count, halt flag and held throttle clear;
// minimum = 0xFFFF, auto_detect = 1, fixed_threshold = 0.
// After the restart limit is reached, input words are still accepted but
// dropped, and no further results appear until reset.
`default_nettype none
module dshot_frame_decoder
	import dfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [DIFF_W-1:0]  cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [DIFF_W-1:0]  period_capture,
	input  wire logic [DIFF_W-1:0]  edge_capture,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [THROT_W-1:0]      throttle_value,
	output logic                    value_updated,
	output logic                    frame_fault,
	output logic                    halted
);
	logic       fe_valid_s1;
	frame_end_t fe_s1;
	diff_arr_t  store_q;
	logic       res_free;

	assign cfg_ready = 1'b1;

	dfd_bit_acc u_acc (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.period_capture (period_capture),
		.edge_capture   (edge_capture),
		.res_free       (res_free),
		.fe_valid_s1    (fe_valid_s1),
		.fe_s1          (fe_s1),
		.store_q        (store_q)
	);

	dfd_frame_judge u_judge (
		.clk            (clk),
		.arst_n         (arst_n),
		.fe_valid_s1    (fe_valid_s1),
		.fe_s1          (fe_s1),
		.store_q        (store_q),
		.res_free       (res_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.throttle_value (throttle_value),
		.value_updated  (value_updated),
		.frame_fault    (frame_fault),
		.halted         (halted)
	);
endmodule
`default_nettype wire

/* rtl/core/dfd_checker.sv */
// Port-level checker for the DShot frame decoder, bound to the top level.
// Uses dfd_pkg and dshot_frame_decoder_assert.svh.
`default_nettype none
`include "dshot_frame_decoder_assert.svh"
module dfd_checker
	import dfd_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [THROT_W-1:0] throttle_value,
	input wire logic               value_updated,
	input wire logic               frame_fault,
	input wire logic               halted
);
	`DFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`DFD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({throttle_value, halted}))
	`DFD_ASSERT_NOW(a_fault_no_update, out_valid, !(frame_fault && value_updated))
	`DFD_ASSERT_NOW(a_halt_on_fault, out_valid && halted, frame_fault)
	`DFD_ASSERT_NEXT(a_silent_after_halt, out_valid && out_ready && halted, !out_valid)
endmodule

bind dshot_frame_decoder dfd_checker u_dfd_checker (.*);
`default_nettype wire
